/* design/ddrm_pkg.sv */
// ----------------------------------------------------------------------------
// ddrm_pkg
// Shared types and constants for the detection dedup and running mean block.
// ----------------------------------------------------------------------------
package ddrm_pkg;

    localparam int MaxEntriesDefault = 16;
    localparam logic [16:0] HitMax = 17'd65535;

    // Action codes of a result.
    typedef enum logic [1:0] {
        ACT_DROP  = 2'd0,
        ACT_NEW   = 2'd1,
        ACT_MERGE = 2'd2,
        ACT_FULL  = 2'd3
    } action_t;

    // Configuration register indexes.
    localparam logic [0:0] CFG_RADIUS = 1'b0;
    localparam logic [0:0] CFG_MARGIN = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the request and clear search state
        logic cmp;        // compare the entry at the search pointer
        logic step;       // advance the search pointer
        logic div_start;  // start the three mean dividers
        logic commit;     // write the table and build the result
    } ddrm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic border;     // request dropped at the border
        logic hit;        // compare hit at the search pointer
        logic scan_done;  // pointer has reached the entry total
        logic full;       // table is full
        logic div_done;   // all three dividers finished
    } ddrm_sts_t;

endpackage

/* design/detection_dedup_running_mean.sv */
// ----------------------------------------------------------------------------
// detection_dedup_running_mean
// Deduplicates detections by XY radius and keeps a running mean per entry.
// ----------------------------------------------------------------------------
// A border drop goes from the check straight to commit; a new entry or a full
// table first walks the n stored entries one per cycle, and a merge at entry
// k walks entries 0 to k and then waits on the 18 step serial mean divide.
// One request is processed at a time; the next is taken once the previous one
// commits, and a commit waits only while an unread result holds the output.
// Reset clears the entry count and restores the default configuration; table contents need no clear.
module detection_dedup_running_mean #(
    parameter int MAX_ENTRIES = ddrm_pkg::MaxEntriesDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_idx,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // det_x, det_y, world_x, world_y, world_z
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // action, entry_index, save_photo, entry_count, mean_x, mean_y, mean_z, zero pad
    output logic [63:0] m_tdata
);
    import ddrm_pkg::*;

    ddrm_cmd_t cmd;
    ddrm_sts_t sts;

    ddrm_ctrl u_ctrl (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready),
        .out_busy(m_tvalid && !m_tready), .sts, .cmd
    );

    ddrm_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
        .aclk, .aresetn, .cfg_wr_en, .cfg_wr_idx, .cfg_wr_data,
        .in_data(s_tdata), .cmd, .sts,
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
    );
endmodule

/* design/ddrm_div.sv */
// ----------------------------------------------------------------------------
// ddrm_div
// Serial signed divider: 18 bit dividend by 17 bit positive divisor,
// quotient truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ddrm_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [17:0] dividend,
    input  logic [16:0]        divisor,
    output logic               done,
    output logic signed [17:0] quotient
);
    logic [17:0] mag_reg, mag_next;
    logic [17:0] quo_reg, quo_next;
    logic [17:0] rem_reg, rem_next;
    logic [16:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [18:0] trial;
    logic [17:0] shifted;

    // One restoring step per cycle.
    always_comb begin
        mag_next  = mag_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg[16:0], mag_reg[17]};
        trial     = {1'b0, shifted} - {2'b00, dvs_reg};
        if (start) begin
            neg_next  = dividend[17];
            mag_next  = dividend[17] ? 18'(-dividend) : 18'(dividend);
            dvs_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = 5'd18;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            mag_next = {mag_reg[16:0], 1'b0};
            if (!trial[18]) begin
                rem_next = trial[17:0];
                quo_next = {quo_reg[16:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[16:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        mag_reg <= mag_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = busy_reg && (cnt_reg == 5'd1);
    assign quotient = neg_reg ? -$signed(quo_next) : $signed(quo_next);
endmodule

/* design/ddrm_ctrl.sv */
// ----------------------------------------------------------------------------
// ddrm_ctrl
// Controller: sequences the border test, the table walk, the mean divide
// and the commit of one request.
// ----------------------------------------------------------------------------
module ddrm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               out_busy,
    input  ddrm_pkg::ddrm_sts_t sts,
    output ddrm_pkg::ddrm_cmd_t cmd
);
    import ddrm_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CHECK  = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_DIV    = 6'b001000,
        ST_WAIT   = 6'b010000,
        ST_COMMIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.border) begin
                    state_next = ST_COMMIT;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (sts.scan_done) begin
                    state_next = ST_COMMIT;
                end else begin
                    cmd.cmp = 1'b1;
                    if (sts.hit) begin
                        state_next = ST_DIV;
                    end else begin
                        cmd.step = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_start = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT: begin
                if (sts.div_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                // The result register must be free or emptying at this edge.
                if (!out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

/* design/ddrm_dp.sv */
// ----------------------------------------------------------------------------
// ddrm_dp
// Datapath: entry table, XY distance compare, serial mean dividers and
// result register.
// ----------------------------------------------------------------------------
module ddrm_dp #(
    parameter int MAX_ENTRIES = ddrm_pkg::MaxEntriesDefault
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_idx,
    input  logic [15:0]        cfg_wr_data,
    input  logic [79:0]        in_data,
    input  ddrm_pkg::ddrm_cmd_t cmd,
    output ddrm_pkg::ddrm_sts_t sts,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [63:0]        out_data
);
    import ddrm_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    // Configuration registers.
    logic [15:0] radius_reg;
    logic [14:0] margin_reg;

    // Request registers.
    logic [15:0] dx_reg, dy_reg;
    logic signed [15:0] wx_reg, wy_reg, wz_reg;
    logic [31:0] csq_reg;
    logic [31:0] r2_reg;

    // Search state.
    logic [CW-1:0] ptr_reg, total_reg;
    logic          found_reg;

    // Entry table.
    logic signed [15:0] ex_mem [MAX_ENTRIES];
    logic signed [15:0] ey_mem [MAX_ENTRIES];
    logic signed [15:0] ez_mem [MAX_ENTRIES];
    logic [15:0]        hc_mem [MAX_ENTRIES];
    logic [31:0]        bc_mem [MAX_ENTRIES];

    logic [IW-1:0] pidx;
    assign pidx = ptr_reg[IW-1:0];

    // Border test on the captured request.
    logic [16:0] hi_lim;
    logic        border;
    assign hi_lim = 17'd65536 - {2'b00, margin_reg};
    assign border = (dx_reg < {1'b0, margin_reg}) || ({1'b0, dx_reg} > hi_lim)
                 || (dy_reg < {1'b0, margin_reg}) || ({1'b0, dy_reg} > hi_lim);

    // Squared XY distance to the entry at the pointer.
    logic signed [16:0] ddx, ddy;
    logic [33:0] d2;
    assign ddx = 17'(wx_reg) - 17'(ex_mem[pidx]);
    assign ddy = 17'(wy_reg) - 17'(ey_mem[pidx]);
    assign d2  = 34'(ddx * ddx) + 34'(ddy * ddy);

    // Frame-center distance of the incoming request.
    logic signed [16:0] icx, icy;
    assign icx = $signed({1'b0, in_data[15:0]}) - 17'sd32768;
    assign icy = $signed({1'b0, in_data[31:16]}) - 17'sd32768;

    // Saturating hit count and dividers.
    logic [15:0] hc_old;
    logic [16:0] hc_new;
    assign hc_old = hc_mem[pidx];
    assign hc_new = ({1'b0, hc_old} < HitMax) ? 17'(hc_old) + 17'd1 : HitMax;

    logic        dv_done_x, dv_done_y, dv_done_z;
    logic signed [17:0] qx, qy, qz;
    logic signed [17:0] qx_reg, qy_reg, qz_reg;

    ddrm_div u_div_x (.aclk, .aresetn, .start(cmd.div_start),
        .dividend(18'(wx_reg) - 18'(ex_mem[pidx])), .divisor(hc_new),
        .done(dv_done_x), .quotient(qx));
    ddrm_div u_div_y (.aclk, .aresetn, .start(cmd.div_start),
        .dividend(18'(wy_reg) - 18'(ey_mem[pidx])), .divisor(hc_new),
        .done(dv_done_y), .quotient(qy));
    ddrm_div u_div_z (.aclk, .aresetn, .start(cmd.div_start),
        .dividend(18'(wz_reg) - 18'(ez_mem[pidx])), .divisor(hc_new),
        .done(dv_done_z), .quotient(qz));

    assign sts.border    = border;
    assign sts.hit       = (d2 < 34'(r2_reg));
    assign sts.scan_done = (ptr_reg == total_reg);
    assign sts.full      = (total_reg == CW'(MAX_ENTRIES));
    assign sts.div_done  = dv_done_x && dv_done_y && dv_done_z;

    // New mean values.
    logic signed [15:0] mx, my, mz;
    assign mx = 16'(18'(ex_mem[pidx]) + qx_reg);
    assign my = 16'(18'(ey_mem[pidx]) + qy_reg);
    assign mz = 16'(18'(ez_mem[pidx]) + qz_reg);

    // Result fields.
    action_t     act;
    logic [3:0]  oidx;
    logic        osave;
    logic [4:0]  ocnt;
    logic [15:0] omx, omy, omz;
    logic [IW-1:0] tidx;
    assign tidx = total_reg[IW-1:0];

    always_comb begin
        act   = ACT_DROP;
        oidx  = '0;
        osave = 1'b0;
        ocnt  = 5'(total_reg);
        omx   = '0;
        omy   = '0;
        omz   = '0;
        priority if (border) begin
            act = ACT_DROP;
        end else if (found_reg) begin
            act   = ACT_MERGE;
            oidx  = 4'(ptr_reg);
            osave = csq_reg < bc_mem[pidx];
            omx   = mx;
            omy   = my;
            omz   = mz;
        end else if (!sts.full) begin
            act   = ACT_NEW;
            oidx  = 4'(total_reg);
            osave = 1'b1;
            ocnt  = 5'(total_reg + CW'(1));
            omx   = wx_reg;
            omy   = wy_reg;
            omz   = wz_reg;
        end else begin
            act = ACT_FULL;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= 16'd192;
            margin_reg <= 15'd5243;
            total_reg  <= '0;
            ptr_reg    <= '0;
            found_reg  <= 1'b0;
            out_valid  <= 1'b0;
        end else begin
            if (cfg_wr_en && cfg_wr_idx == CFG_RADIUS) begin
                radius_reg <= cfg_wr_data;
            end
            if (cfg_wr_en && cfg_wr_idx == CFG_MARGIN) begin
                margin_reg <= cfg_wr_data[14:0];
            end
            if (out_valid && out_ready) begin
                out_valid <= 1'b0;
            end
            if (cmd.load) begin
                ptr_reg   <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.step) begin
                ptr_reg <= ptr_reg + CW'(1);
            end
            if (cmd.cmp && sts.hit) begin
                found_reg <= 1'b1;
            end
            if (cmd.commit) begin
                out_valid <= 1'b1;
                if (!border && !found_reg && !sts.full) begin
                    total_reg <= total_reg + CW'(1);
                end
            end
        end
    end

    // Payload registers and table writes.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dx_reg  <= in_data[15:0];
            dy_reg  <= in_data[31:16];
            wx_reg  <= in_data[47:32];
            wy_reg  <= in_data[63:48];
            wz_reg  <= in_data[79:64];
            csq_reg <= 32'(icx * icx) + 32'(icy * icy);
            r2_reg  <= radius_reg * radius_reg;
        end
        if (sts.div_done) begin
            qx_reg <= qx;
            qy_reg <= qy;
            qz_reg <= qz;
        end
        if (cmd.commit) begin
            out_data <= {4'b0000, omz, omy, omx, ocnt, osave, oidx, act};
            if (!border && found_reg) begin
                ex_mem[pidx] <= mx;
                ey_mem[pidx] <= my;
                ez_mem[pidx] <= mz;
                hc_mem[pidx] <= hc_new[15:0];
                if (osave) begin
                    bc_mem[pidx] <= csq_reg;
                end
            end else if (!border && !sts.full) begin
                ex_mem[tidx] <= wx_reg;
                ey_mem[tidx] <= wy_reg;
                ez_mem[tidx] <= wz_reg;
                hc_mem[tidx] <= 16'd1;
                bc_mem[tidx] <= csq_reg;
            end
        end
    end
endmodule

/* tb/sv/ddrm_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ddrm_checker
// Watches the configuration port and both streams of the dedup block. It keeps
// its own copy of the detection table, predicts the result of every accepted
// request and compares each returned result with the oldest prediction.
// ----------------------------------------------------------------------------
module ddrm_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_idx,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    output int          pending,
    output int          failures,
    output int          merges_seen,
    output int          full_seen
);
    import ddrm_pkg::*;

    localparam int TableDepth = 16;
    localparam logic [16:0] OneQ016 = 17'd65536;

    typedef struct packed {
        action_t     action;
        logic [3:0]  entry_index;
        logic        save_photo;
        logic [4:0]  entry_count;
        logic [15:0] mean_x;
        logic [15:0] mean_y;
        logic [15:0] mean_z;
    } dedup_result_t;

    // Shadow copy of the configuration and the detection table.
    logic [15:0] radius_q88;
    logic [14:0] margin_q016;
    logic signed [15:0] tbl_x [TableDepth];
    logic signed [15:0] tbl_y [TableDepth];
    logic signed [15:0] tbl_z [TableDepth];
    logic [15:0] tbl_hits [TableDepth];
    logic [31:0] tbl_best [TableDepth];
    int          tbl_fill;

    dedup_result_t expected_results[$];

    // Moves one coordinate of an entry toward the detection, quotient truncated.
    function automatic logic signed [15:0] mean_step(logic signed [15:0] old_v,
                                                     logic signed [15:0] det_v,
                                                     logic [15:0] hits);
        int diff;
        diff = int'(det_v) - int'(old_v);
        return 16'(int'(old_v) + diff / int'(hits));
    endfunction

    // Applies one detection to the shadow table and returns the result it gives.
    function automatic dedup_result_t table_update(logic [79:0] det);
        dedup_result_t r;
        logic [15:0] cx_img, cy_img;
        logic signed [15:0] wx, wy, wz;
        logic [16:0] hi_lim;
        int cx, cy;
        logic [31:0] csq;
        longint r2, ex, ey, d2;
        int hit_at;
        cx_img = det[15:0];
        cy_img = det[31:16];
        wx = det[47:32];
        wy = det[63:48];
        wz = det[79:64];
        r = '0;
        r.action = ACT_DROP;
        hi_lim = OneQ016 - 17'(margin_q016);
        if (!(cx_img < margin_q016 || 17'(cx_img) > hi_lim ||
              cy_img < margin_q016 || 17'(cy_img) > hi_lim)) begin
            cx = int'(cx_img) - 32768;
            cy = int'(cy_img) - 32768;
            csq = 32'(cx * cx) + 32'(cy * cy);
            r2 = longint'(radius_q88) * longint'(radius_q88);
            hit_at = -1;
            for (int i = 0; i < tbl_fill; i++) begin
                ex = longint'(wx) - longint'(tbl_x[i]);
                ey = longint'(wy) - longint'(tbl_y[i]);
                d2 = ex * ex + ey * ey;
                if (hit_at < 0 && d2 < r2) begin
                    hit_at = i;
                end
            end
            if (hit_at >= 0) begin
                if (tbl_hits[hit_at] != 16'hFFFF) begin
                    tbl_hits[hit_at]++;
                end
                tbl_x[hit_at] = mean_step(tbl_x[hit_at], wx, tbl_hits[hit_at]);
                tbl_y[hit_at] = mean_step(tbl_y[hit_at], wy, tbl_hits[hit_at]);
                tbl_z[hit_at] = mean_step(tbl_z[hit_at], wz, tbl_hits[hit_at]);
                if (csq < tbl_best[hit_at]) begin
                    tbl_best[hit_at] = csq;
                    r.save_photo = 1'b1;
                end
                r.action = ACT_MERGE;
                r.entry_index = 4'(hit_at);
                r.mean_x = tbl_x[hit_at];
                r.mean_y = tbl_y[hit_at];
                r.mean_z = tbl_z[hit_at];
            end else if (tbl_fill < TableDepth) begin
                tbl_x[tbl_fill] = wx;
                tbl_y[tbl_fill] = wy;
                tbl_z[tbl_fill] = wz;
                tbl_hits[tbl_fill] = 16'd1;
                tbl_best[tbl_fill] = csq;
                r.action = ACT_NEW;
                r.entry_index = 4'(tbl_fill);
                r.save_photo = 1'b1;
                r.mean_x = wx;
                r.mean_y = wy;
                r.mean_z = wz;
                tbl_fill++;
            end else begin
                r.action = ACT_FULL;
            end
        end
        r.entry_count = 5'(tbl_fill);
        return r;
    endfunction

    assign pending = expected_results.size();

    // Follow the configuration, predict on accepted requests, check results.
    always @(posedge aclk) begin
        dedup_result_t want, got;
        if (!aresetn) begin
            radius_q88 <= 16'd192;
            margin_q016 <= 15'd5243;
            tbl_fill = 0;
            expected_results.delete();
            failures <= 0;
            merges_seen <= 0;
            full_seen <= 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_wr_idx == CFG_RADIUS) begin
                    radius_q88 <= cfg_wr_data;
                end else begin
                    margin_q016 <= cfg_wr_data[14:0];
                end
            end
            if (m_tvalid && m_tready) begin
                got.action = action_t'(m_tdata[1:0]);
                got.entry_index = m_tdata[5:2];
                got.save_photo = m_tdata[6];
                got.entry_count = m_tdata[11:7];
                got.mean_x = m_tdata[27:12];
                got.mean_y = m_tdata[43:28];
                got.mean_z = m_tdata[59:44];
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding: %h", m_tdata);
                    failures <= failures + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got != want) begin
                        failures <= failures + 1;
                    end
                    if (got.action != want.action)
                        $error("action: expected %0d, got %0d", want.action, got.action);
                    if (got.entry_index != want.entry_index)
                        $error("entry_index: expected %0d, got %0d",
                               want.entry_index, got.entry_index);
                    if (got.save_photo != want.save_photo)
                        $error("save_photo: expected %0d, got %0d",
                               want.save_photo, got.save_photo);
                    if (got.entry_count != want.entry_count)
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, got.entry_count);
                    if (got.mean_x != want.mean_x)
                        $error("mean_x: expected %h, got %h", want.mean_x, got.mean_x);
                    if (got.mean_y != want.mean_y)
                        $error("mean_y: expected %h, got %h", want.mean_y, got.mean_y);
                    if (got.mean_z != want.mean_z)
                        $error("mean_z: expected %h, got %h", want.mean_z, got.mean_z);
                    if (want.action == ACT_MERGE) merges_seen <= merges_seen + 1;
                    if (want.action == ACT_FULL) full_seen <= full_seen + 1;
                end
            end
            // Prediction uses the configuration in force before this edge.
            if (s_tvalid && s_tready) begin
                expected_results.insert(expected_results.size(), table_update(s_tdata));
            end
        end
    end

endmodule

/* tb/sv/detection_dedup_running_mean_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// detection_dedup_running_mean_tb
// Drives detections into the dedup block under several radius and margin
// settings, with random stalls on both streams. A checker beside the block
// predicts every result and reports mismatches; this module gives the verdict.
// ----------------------------------------------------------------------------
module detection_dedup_running_mean_tb;
    import ddrm_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_wr_idx;
    logic [15:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    // det_x, det_y, world_x, world_y, world_z
    logic [79:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // action, entry_index, save_photo, entry_count, mean_x, mean_y, mean_z, zero pad
    logic [63:0] m_tdata;

    int pending, failures, merges_seen, full_seen;
    int requests_sent;
    bit quiet_sender;
    bit hold_results;

    logic [14:0] margin_now;
    logic signed [15:0] site_x [16];
    logic signed [15:0] site_y [16];
    logic signed [15:0] site_z [16];

    detection_dedup_running_mean i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_idx(cfg_wr_idx), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    ddrm_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_idx(cfg_wr_idx), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .pending(pending), .failures(failures),
        .merges_seen(merges_seen), .full_seen(full_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Result side: random stalls, a quiet window, and one long hold-off.
    initial begin
        int cyc;
        int held;
        cyc = 0;
        held = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (hold_results) begin
                m_tready <= 1'b0;
                held++;
                if (held >= 400) hold_results = 1'b0;
            end else begin
                held = 0;
                if (cyc > 3000 && cyc < 6000) m_tready <= 1'b1;
                else m_tready <= ($urandom_range(99) >= 20);
            end
        end
    end

    initial begin
        #5ms;
        $display("timeout with %0d requests outstanding", pending);
        $display("FAIL detection_dedup_running_mean");
        $finish;
    end

    task automatic write_reg(logic idx, logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_idx <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_MARGIN) margin_now = value[14:0];
        @(posedge aclk);
    endtask

    // Stops offering requests and waits until every result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // Offers one request, after an optional random gap, until it is taken.
    task automatic send_detection(logic [15:0] dx, logic [15:0] dy,
                                  logic [15:0] wx, logic [15:0] wy, logic [15:0] wz);
        if (!quiet_sender && $urandom_range(99) < 20) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {wz, wy, wx, dy, dx};
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
    endtask

    // Well-formed detection: inside the margins and close to a known site.
    task automatic send_near_site(int spread);
        int k;
        logic [15:0] lo;
        logic [15:0] hi;
        k = $urandom_range(15);
        lo = 16'(margin_now);
        hi = 16'(17'd65536 - 17'(margin_now) - 17'd1);
        if (hi < lo) hi = lo;
        send_detection(16'($urandom_range(hi, lo)), 16'($urandom_range(hi, lo)),
                       16'(int'(site_x[k]) + $urandom_range(2 * spread) - spread),
                       16'(int'(site_y[k]) + $urandom_range(2 * spread) - spread),
                       16'(int'(site_z[k]) + $urandom_range(2 * spread) - spread));
    endtask

    task automatic random_phase(int count, int spread);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 75) send_near_site(spread);
            else send_detection(16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_idx = CFG_RADIUS;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        quiet_sender = 1'b0;
        hold_results = 1'b0;
        requests_sent = 0;
        margin_now = 15'd5243;
        for (int k = 0; k < 16; k++) begin
            site_x[k] = 16'($urandom_range(60000) - 30000);
            site_y[k] = 16'($urandom_range(60000) - 30000);
            site_z[k] = 16'($urandom);
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: border edges at the reset margin, extremes, merges.
        send_detection(16'd0, 16'd32768, 16'd0, 16'd0, 16'd0);
        send_detection(16'd32768, 16'd65535, 16'd0, 16'd0, 16'd0);
        send_detection(16'd5242, 16'd32768, 16'd0, 16'd0, 16'd0);
        send_detection(16'd60294, 16'd32768, 16'd0, 16'd0, 16'd0);
        send_detection(16'd5243, 16'd60293, 16'h8000, 16'h8000, 16'h8000);
        send_detection(16'd60293, 16'd5243, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_detection(16'd32768, 16'd32768, 16'h8000, 16'h8000, 16'h7FFF);
        send_detection(16'd40000, 16'd40000, 16'h8050, 16'h8010, 16'h0000);
        send_detection(16'd32768, 16'd32768, 16'h7FFF, 16'h7F50, 16'h8000);
        send_detection(16'd30000, 16'd30000, 16'h0000, 16'h0000, 16'h0100);
        send_detection(16'd32000, 16'd33000, 16'h00BF, 16'h0000, 16'hFF00);
        send_detection(16'd32000, 16'd33000, 16'h00C0, 16'h0000, 16'h0000);
        send_detection(16'd32768, 16'd32768, 16'h0000, 16'h00C0, 16'h0000);
        send_detection(16'd33000, 16'd33000, 16'hFFC0, 16'hFFC0, 16'h1234);
        send_detection(16'd32768, 16'd32768, 16'h0001, 16'hFFFF, 16'hEDCB);
        drain();

        // Medium radius, narrow margin; long result hold-off in the middle.
        write_reg(CFG_RADIUS, 16'd256);
        write_reg(CFG_MARGIN, 16'd3000);
        random_phase(150, 200);
        hold_results = 1'b1;
        random_phase(150, 200);
        drain();
        quiet_sender = 1'b1;
        random_phase(150, 120);
        quiet_sender = 1'b0;
        drain();

        // Zero radius and zero margin: nothing merges, nothing is dropped.
        write_reg(CFG_RADIUS, 16'd0);
        write_reg(CFG_MARGIN, 16'd0);
        random_phase(150, 50);
        drain();

        // Largest radius and margin.
        write_reg(CFG_RADIUS, 16'hFFFF);
        write_reg(CFG_MARGIN, 16'h7FFF);
        random_phase(150, 1000);
        drain();
        write_reg(CFG_MARGIN, 16'd32000);
        random_phase(100, 1000);
        drain();

        // Random settings in several rounds.
        for (int p = 0; p < 4; p++) begin
            write_reg(CFG_RADIUS, 16'($urandom));
            write_reg(CFG_MARGIN, 16'($urandom_range(20000)));
            random_phase(90, $urandom_range(4000, 10));
            drain();
        end

        $display("%0d detections sent over nine settings; %0d merges, %0d table full",
                 requests_sent, merges_seen, full_seen);
        if (failures == 0) begin
            $display("PASS detection_dedup_running_mean");
        end else begin
            $display("FAIL detection_dedup_running_mean");
        end
        $finish;
    end

endmodule

/* sim.f */
design/ddrm_pkg.sv
design/ddrm_div.sv
design/ddrm_ctrl.sv
design/ddrm_dp.sv
design/detection_dedup_running_mean.sv
tb/sv/ddrm_checker.sv
tb/sv/detection_dedup_running_mean_tb.sv
